// ----- rtl/tsfn_pkg.sv -----
// Package for the triangle strip flat normal block.
// Holds the item types of both channels and the shared constants.
// No dependencies.
`default_nettype none
package tsfn_pkg;

    localparam int unsigned CoordW = 32;
    localparam int unsigned NormW  = 16;
    localparam int unsigned ColorW = 32;
    localparam int unsigned PaddrW = 2;
    localparam int unsigned MulW   = 33;

    localparam logic [NormW-1:0] NormMax = 16'h7FFF;

    localparam logic [PaddrW-1:0] AddrStripColor = 2'd0;

    typedef struct packed {
        logic signed [CoordW-1:0] vertex_x;
        logic signed [CoordW-1:0] vertex_y;
        logic signed [CoordW-1:0] vertex_z;
        logic                     strip_start;
    } t_vtx_in;

    typedef struct packed {
        logic signed [CoordW-1:0] out_x;
        logic signed [CoordW-1:0] out_y;
        logic signed [CoordW-1:0] out_z;
        logic signed [NormW-1:0]  normal_x;
        logic signed [NormW-1:0]  normal_y;
        logic signed [NormW-1:0]  normal_z;
        logic [ColorW-1:0]        vertex_color;
        logic                     last_of_triangle;
    } t_vtx_out;

endpackage
`default_nettype wire

// ----- rtl/triangle_strip_flat_normals.sv -----
// Top level of the triangle strip assembler with flat face normals.
// Depends on tsfn_pkg and tsfn_mul.
//
// Each accepted vertex updates the strip history as it is taken; the first two
// vertices of a strip produce no item and the block is ready again at once.
// From the third vertex on, the block computes the face normal and emits three
// items. o_stall stays high from when such a vertex is taken until its last
// item is loaded into the output register, also while the output is stalled;
// a degenerate triangle skips the divisions. The work is six cross-product
// multiplies and three squares on one shared multiplier, a normalizing shift
// right by eight or by one bit per step, a 32-step bit-serial square root,
// three 16-step divisions by compare and subtract, then three output items.
// The output register lets the next vertex be taken while the last item still
// waits.
`default_nettype none
module triangle_strip_flat_normals (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire tsfn_pkg::t_vtx_in                   i_data,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output tsfn_pkg::t_vtx_out                       o_data,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [tsfn_pkg::PaddrW-1:0]         paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);

    typedef enum logic [3:0] {
        S_IDLE, S_EDGE, S_CROSS, S_NORM, S_SQ, S_SQRT, S_DIVINIT, S_DIV, S_OUT
    } t_state;

    t_state r_state;
    logic [31:0]        r_color;
    logic signed [31:0] r_hx [2];
    logic signed [31:0] r_hy [2];
    logic signed [31:0] r_hz [2];
    logic [1:0]         r_seen;
    logic               r_par;

    logic signed [31:0] r_p1 [3];
    logic signed [31:0] r_p2 [3];
    logic signed [31:0] r_p3 [3];
    logic signed [32:0] r_u [3];
    logic signed [32:0] r_v [3];
    logic signed [65:0] r_acc;
    logic [64:0]        r_mag [3];
    logic               r_neg [3];
    logic [61:0]        r_sum;
    logic [62:0]        r_res;
    logic [62:0]        r_bit;
    logic [46:0]        r_rem;
    logic [46:0]        r_dv;
    logic [15:0]        r_q;
    logic [3:0]         r_step;
    logic [2:0]         r_cnt;
    logic [15:0]        r_nrm [3];
    logic               r_ovalid;
    tsfn_pkg::t_vtx_out r_odata;

    logic signed [32:0] w_ma;
    logic signed [32:0] w_mb;
    logic signed [65:0] w_prod;
    logic signed [66:0] w_diff;
    logic signed [66:0] w_abs;
    logic [64:0]        w_or;
    logic [63:0]        w_t;
    logic               w_qbit;
    logic [15:0]        w_qn;
    logic [15:0]        w_nsat;
    logic [30:0]        w_len;
    logic               w_accept;
    logic               w_start;
    logic [1:0]         w_seen;
    logic               w_par;
    logic               w_oload;
    logic [1:0]         w_k;

    tsfn_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_ma),
        .i_b    (w_mb),
        .o_prod (w_prod)
    );

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_CROSS: begin
                case (r_cnt)
                    3'd0: begin w_ma = r_u[1]; w_mb = r_v[2]; end
                    3'd1: begin w_ma = r_u[2]; w_mb = r_v[1]; end
                    3'd2: begin w_ma = r_u[2]; w_mb = r_v[0]; end
                    3'd3: begin w_ma = r_u[0]; w_mb = r_v[2]; end
                    3'd4: begin w_ma = r_u[0]; w_mb = r_v[1]; end
                    3'd5: begin w_ma = r_u[1]; w_mb = r_v[0]; end
                    default: begin w_ma = '0; w_mb = '0; end
                endcase
            end
            S_SQ: begin
                case (r_cnt)
                    3'd0: begin w_ma = {3'b0, r_mag[0][29:0]}; end
                    3'd1: begin w_ma = {3'b0, r_mag[1][29:0]}; end
                    3'd2: begin w_ma = {3'b0, r_mag[2][29:0]}; end
                    default: begin w_ma = '0; end
                endcase
                w_mb = w_ma;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_diff  = {r_acc[65], r_acc} - {w_prod[65], w_prod};
    assign w_abs   = w_diff[66] ? -w_diff : w_diff;
    assign w_or    = r_mag[0] | r_mag[1] | r_mag[2];
    assign w_t     = {1'b0, r_res} + {1'b0, r_bit};
    assign w_len   = r_res[30:0];
    assign w_k     = r_cnt[1:0];
    assign w_qbit  = (r_rem >= r_dv);
    assign w_qn    = {r_q[14:0], w_qbit};
    assign w_nsat  = r_neg[w_k] ? (16'd0 - w_qn) :
                     ((w_qn > tsfn_pkg::NormMax) ? tsfn_pkg::NormMax : w_qn);

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_start  = i_data.strip_start;
    assign w_seen   = w_start ? 2'd0 : r_seen;
    assign w_par    = w_start ? 1'b0 : r_par;
    assign w_oload  = (r_state == S_OUT) && (!r_ovalid || !i_stall);

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign prdata  = r_color;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_color  <= '0;
            r_seen   <= '0;
            r_par    <= 1'b0;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_hx[0]  <= '0;
            r_hx[1]  <= '0;
            r_hy[0]  <= '0;
            r_hy[1]  <= '0;
            r_hz[0]  <= '0;
            r_hz[1]  <= '0;
        end else begin
            if (psel && penable && pwrite && (paddr == tsfn_pkg::AddrStripColor)) begin
                r_color <= pwdata;
            end
            if (w_oload) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_hx[1] <= r_hx[0];
                        r_hy[1] <= r_hy[0];
                        r_hz[1] <= r_hz[0];
                        r_hx[0] <= i_data.vertex_x;
                        r_hy[0] <= i_data.vertex_y;
                        r_hz[0] <= i_data.vertex_z;
                        r_par   <= !w_par;
                        r_p1[0] <= i_data.vertex_x;
                        r_p1[1] <= i_data.vertex_y;
                        r_p1[2] <= i_data.vertex_z;
                        r_p2[0] <= w_par ? r_hx[1] : r_hx[0];
                        r_p2[1] <= w_par ? r_hy[1] : r_hy[0];
                        r_p2[2] <= w_par ? r_hz[1] : r_hz[0];
                        r_p3[0] <= w_par ? r_hx[0] : r_hx[1];
                        r_p3[1] <= w_par ? r_hy[0] : r_hy[1];
                        r_p3[2] <= w_par ? r_hz[0] : r_hz[1];
                        if (w_seen == 2'd2) begin
                            r_seen  <= w_seen;
                            r_state <= S_EDGE;
                        end else begin
                            r_seen <= w_seen + 2'd1;
                        end
                    end
                end
                S_EDGE: begin
                    for (int k = 0; k < 3; k++) begin
                        r_u[k] <= {r_p2[k][31], r_p2[k]} - {r_p1[k][31], r_p1[k]};
                        r_v[k] <= {r_p3[k][31], r_p3[k]} - {r_p1[k][31], r_p1[k]};
                    end
                    r_sum   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_CROSS;
                end
                S_CROSS: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt != 3'd0) begin
                        if (r_cnt[0]) begin
                            r_acc <= w_prod;
                        end else begin
                            r_mag[r_cnt[2:1] - 2'd1] <= w_abs[64:0];
                            r_neg[r_cnt[2:1] - 2'd1] <= w_diff[66];
                        end
                    end
                    if (r_cnt == 3'd6) begin
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (|w_or[64:38]) begin
                        for (int k = 0; k < 3; k++) begin
                            r_mag[k] <= r_mag[k] >> 8;
                        end
                    end else if (|w_or[64:30]) begin
                        for (int k = 0; k < 3; k++) begin
                            r_mag[k] <= r_mag[k] >> 1;
                        end
                    end else begin
                        r_cnt   <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt != 3'd0) begin
                        r_sum <= r_sum + w_prod[61:0];
                    end
                    if (r_cnt == 3'd3) begin
                        r_res   <= '0;
                        r_bit   <= {1'b1, 62'b0};
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if ({2'b0, r_sum} >= w_t) begin
                        r_sum <= r_sum - w_t[61:0];
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_cnt   <= '0;
                        r_state <= S_DIVINIT;
                    end
                end
                S_DIVINIT: begin
                    if (w_len == '0) begin
                        r_nrm[w_k] <= '0;
                        if (w_k == 2'd2) begin
                            r_cnt   <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_cnt <= r_cnt + 3'd1;
                        end
                    end else begin
                        r_rem   <= {2'b0, r_mag[w_k][29:0], 15'b0}
                                   + {17'b0, w_len[30:1]};
                        r_dv    <= {1'b0, w_len, 15'b0};
                        r_q     <= '0;
                        r_step  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_qbit) begin
                        r_rem <= r_rem - r_dv;
                    end
                    r_q    <= w_qn;
                    r_dv   <= r_dv >> 1;
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'hF) begin
                        r_nrm[w_k] <= w_nsat;
                        if (w_k == 2'd2) begin
                            r_cnt   <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_cnt   <= r_cnt + 3'd1;
                            r_state <= S_DIVINIT;
                        end
                    end
                end
                S_OUT: begin
                    if (w_oload) begin
                        case (w_k)
                            2'd0: begin
                                r_odata.out_x <= r_p1[0];
                                r_odata.out_y <= r_p1[1];
                                r_odata.out_z <= r_p1[2];
                            end
                            2'd1: begin
                                r_odata.out_x <= r_p3[0];
                                r_odata.out_y <= r_p3[1];
                                r_odata.out_z <= r_p3[2];
                            end
                            default: begin
                                r_odata.out_x <= r_p2[0];
                                r_odata.out_y <= r_p2[1];
                                r_odata.out_z <= r_p2[2];
                            end
                        endcase
                        r_odata.normal_x         <= r_nrm[0];
                        r_odata.normal_y         <= r_nrm[1];
                        r_odata.normal_z         <= r_nrm[2];
                        r_odata.vertex_color     <= r_color;
                        r_odata.last_of_triangle <= (w_k == 2'd2);
                        if (w_k == 2'd2) begin
                            r_cnt   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_cnt <= r_cnt + 3'd1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/tsfn_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on tsfn_pkg for the operand width.
`default_nettype none
module tsfn_mul (
    input  wire logic                                 i_clk,
    input  wire logic signed [tsfn_pkg::MulW-1:0]     i_a,
    input  wire logic signed [tsfn_pkg::MulW-1:0]     i_b,
    output logic signed      [2*tsfn_pkg::MulW-1:0]   o_prod
);

    logic signed [2*tsfn_pkg::MulW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for triangle_strip_flat_normals.
// Drives strip vertices and APB writes, predicts each emitted triangle vertex
// with an internal face-normal model, and compares items in order. Uses tsfn_pkg.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    tsfn_pkg::t_vtx_in i_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    tsfn_pkg::t_vtx_out o_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [tsfn_pkg::PaddrW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    triangle_strip_flat_normals dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    tsfn_pkg::t_vtx_out expected_vertices[$];
    int errors = 0;
    logic [31:0] color_reg = '0;
    logic signed [31:0] hist_x[2], hist_y[2], hist_z[2];
    int seen_count = 0;
    bit parity_bit = 1'b0;
    int gap_pct = 16;
    bit hold_output = 1'b0;

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic void face_normal(input logic signed [31:0] a[3],
            input logic signed [31:0] b[3], input logic signed [31:0] c[3],
            output logic [15:0] nrm[3]);
        logic signed [32:0] u[3], v[3];
        logic signed [67:0] cr[3];
        logic [67:0] mag[3];
        logic [63:0] m[3], sum, len, q;
        int s, bl;
        for (int k = 0; k < 3; k++) begin
            u[k] = 33'(b[k]) - 33'(a[k]);
            v[k] = 33'(c[k]) - 33'(a[k]);
        end
        cr[0] = 68'(u[1]) * 68'(v[2]) - 68'(u[2]) * 68'(v[1]);
        cr[1] = 68'(u[2]) * 68'(v[0]) - 68'(u[0]) * 68'(v[2]);
        cr[2] = 68'(u[0]) * 68'(v[1]) - 68'(u[1]) * 68'(v[0]);
        s = 0;
        for (int k = 0; k < 3; k++) begin
            mag[k] = cr[k] < 0 ? 68'(-cr[k]) : 68'(cr[k]);
            bl = 0;
            for (int i = 0; i < 68; i++) if (mag[k][i]) bl = i + 1;
            if (bl > 30 && bl - 30 > s) s = bl - 30;
        end
        sum = 0;
        for (int k = 0; k < 3; k++) begin
            m[k] = 64'(mag[k] >> s);
            sum = sum + m[k] * m[k];
        end
        len = int_sqrt(sum);
        for (int k = 0; k < 3; k++) begin
            if (len == 0) begin
                nrm[k] = '0;
            end else begin
                q = (m[k] * 64'd32768 + len / 2) / len;
                if (cr[k] < 0) begin
                    if (q > 32768) q = 32768;
                    nrm[k] = 16'(64'd65536 - q);
                end else begin
                    if (q > 32767) q = 32767;
                    nrm[k] = 16'(q);
                end
            end
        end
    endfunction

    function automatic tsfn_pkg::t_vtx_out make_vertex(logic signed [31:0] p[3],
            logic [15:0] nrm[3], logic last);
        tsfn_pkg::t_vtx_out o;
        o.out_x = p[0];
        o.out_y = p[1];
        o.out_z = p[2];
        o.normal_x = nrm[0];
        o.normal_y = nrm[1];
        o.normal_z = nrm[2];
        o.vertex_color = color_reg;
        o.last_of_triangle = last;
        return o;
    endfunction

    function automatic void predict_triangle(tsfn_pkg::t_vtx_in item);
        logic signed [31:0] cur[3], prv[3], old[3];
        logic [15:0] nrm[3];
        bit par;
        cur = '{item.vertex_x, item.vertex_y, item.vertex_z};
        if (item.strip_start) begin
            seen_count = 0;
            parity_bit = 1'b0;
        end
        par = parity_bit;
        if (seen_count >= 2) begin
            prv = '{hist_x[0], hist_y[0], hist_z[0]};
            old = '{hist_x[1], hist_y[1], hist_z[1]};
            if (!par) begin
                face_normal(cur, prv, old, nrm);
                expected_vertices.push_back(make_vertex(cur, nrm, 1'b0));
                expected_vertices.push_back(make_vertex(old, nrm, 1'b0));
                expected_vertices.push_back(make_vertex(prv, nrm, 1'b1));
            end else begin
                face_normal(cur, old, prv, nrm);
                expected_vertices.push_back(make_vertex(cur, nrm, 1'b0));
                expected_vertices.push_back(make_vertex(prv, nrm, 1'b0));
                expected_vertices.push_back(make_vertex(old, nrm, 1'b1));
            end
        end else begin
            seen_count++;
        end
        hist_x[1] = hist_x[0];
        hist_y[1] = hist_y[0];
        hist_z[1] = hist_z[0];
        hist_x[0] = item.vertex_x;
        hist_y[0] = item.vertex_y;
        hist_z[0] = item.vertex_z;
        parity_bit = ~par;
    endfunction

    task automatic send_vertex(tsfn_pkg::t_vtx_in item);
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_data <= item;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        predict_triangle(item);
        @(negedge i_clk);
    endtask

    task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
            logic signed [31:0] z, logic start);
        tsfn_pkg::t_vtx_in item;
        item.vertex_x = x;
        item.vertex_y = y;
        item.vertex_z = z;
        item.strip_start = start;
        send_vertex(item);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_vertices.size() != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
    endtask

    task automatic write_color(logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= tsfn_pkg::AddrStripColor;
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        color_reg = value;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(2000)) - 1000;
            2: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return $signed(($urandom_range(255) << 16) - 32'h800000);
        endcase
    endfunction

    task automatic test_directed();
        write_color(32'h0);
        send_point(0, 0, 0, 1'b0);
        send_point(32'sh10000, 0, 0, 1'b0);
        send_point(0, 32'sh10000, 0, 1'b0);
        send_point(32'sh10000, 32'sh10000, 0, 1'b0);
        send_point(5, 5, 5, 1'b1);
        send_point(5, 5, 5, 1'b0);
        send_point(5, 5, 5, 1'b0);
        send_point(1, 2, 3, 1'b0);
        send_point(2, 4, 6, 1'b0);
        send_point(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1'b1);
        send_point(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 1'b0);
        send_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 1'b0);
        send_point(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 1'b0);
        send_point(-1, -1, -1, 1'b1);
        send_point(0, 0, 0, 1'b1);
        send_point(7, 0, 0, 1'b0);
        send_point(0, 7, 0, 1'b0);
        send_point(0, 0, 7, 1'b0);
        wait_drained();
        write_color(32'hFFFFFFFF);
        send_point(0, 0, 0, 1'b1);
        send_point(0, 0, 32'sh10000, 1'b0);
        send_point(32'sh10000, 0, 0, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_strips(int count);
        int sent;
        int len;
        int mode;
        sent = 0;
        while (sent < count) begin
            len = $urandom_range(9) < 8 ? $urandom_range(12, 3) : $urandom_range(2, 1);
            mode = $urandom_range(3);
            for (int i = 0; i < len && sent < count; i++) begin
                send_point(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                           i == 0 ? 1'b1 : ($urandom_range(30) == 0));
                sent++;
            end
        end
    endtask

    task automatic test_backpressure();
        hold_output = 1'b1;
        gap_pct = 0;
        send_point(1, 2, 3, 1'b1);
        send_point(-40000, 9, 77, 1'b0);
        for (int i = 0; i < 6; i++) send_point(rand_coord(1), rand_coord(0), rand_coord(3), 1'b0);
        wait_drained();
        gap_pct = 16;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        write_color($urandom);
        test_random_strips(150);
        wait_drained();
        gap_pct = 0;
        write_color(32'h12345678);
        test_random_strips(100);
        wait_drained();
        gap_pct = 16;
        test_backpressure();
        write_color($urandom);
        test_random_strips(190);
        wait_drained();
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Output stall: random, except a quiet stretch and a long forced hold-off.
    initial begin
        int hold;
        forever begin
            @(negedge i_clk);
            if (hold_output) begin
                i_stall <= 1'b1;
                hold = 0;
                while (hold < 800) begin
                    @(negedge i_clk);
                    hold++;
                end
                hold_output = 1'b0;
                i_stall <= 1'b0;
            end else if ($time > 40000 && $time < 90000) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < 16);
            end
        end
    end

    always @(posedge i_clk) begin
        tsfn_pkg::t_vtx_out exp_v;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_vertices.size() == 0) begin
                $display("%0t: unexpected item %p", $time, o_data);
                errors++;
            end else begin
                exp_v = expected_vertices.pop_front();
                if (o_data.out_x !== exp_v.out_x)
                    $display("%0t: out_x exp %h got %h", $time, exp_v.out_x, o_data.out_x);
                if (o_data.out_y !== exp_v.out_y)
                    $display("%0t: out_y exp %h got %h", $time, exp_v.out_y, o_data.out_y);
                if (o_data.out_z !== exp_v.out_z)
                    $display("%0t: out_z exp %h got %h", $time, exp_v.out_z, o_data.out_z);
                if (o_data.normal_x !== exp_v.normal_x)
                    $display("%0t: normal_x exp %h got %h", $time, exp_v.normal_x,
                             o_data.normal_x);
                if (o_data.normal_y !== exp_v.normal_y)
                    $display("%0t: normal_y exp %h got %h", $time, exp_v.normal_y,
                             o_data.normal_y);
                if (o_data.normal_z !== exp_v.normal_z)
                    $display("%0t: normal_z exp %h got %h", $time, exp_v.normal_z,
                             o_data.normal_z);
                if (o_data.vertex_color !== exp_v.vertex_color)
                    $display("%0t: vertex_color exp %h got %h", $time, exp_v.vertex_color,
                             o_data.vertex_color);
                if (o_data.last_of_triangle !== exp_v.last_of_triangle)
                    $display("%0t: last_of_triangle exp %b got %b", $time,
                             exp_v.last_of_triangle, o_data.last_of_triangle);
                if (o_data !== exp_v) errors++;
            end
        end
    end

    initial begin
        #3000000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire
